FILE: rtl/core/battery_voltage_monitor_defines.svh
// ----------------------------------------------------------------------------
// Battery voltage monitor assertion macros
// Shared property wrappers for the checker of the supply voltage monitor.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_DEFINES_SVH
`define BATTERY_VOLTAGE_MONITOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BVM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bvm_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Field widths, register indexes, grade codes and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int VOLT_W     = 24;
  localparam int THR_W      = 16;
  localparam int LEVEL_W    = 2;
  localparam int DVS_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_OK   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_CRIT = 2'd2;

  localparam logic [VOLT_W-1:0] VOLT_MAX    = 24'hFF_FFFF;
  localparam logic [VOLT_W-1:0] SCALE_RESET = 24'd5013504;
  localparam logic [THR_W-1:0]  HIGH_RESET  = 16'd2400;
  localparam logic [THR_W-1:0]  LOW_RESET   = 16'd2200;

  typedef struct packed {
    logic [VOLT_W-1:0] scale;
    logic [THR_W-1:0]  high_thr;
    logic [THR_W-1:0]  low_thr;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [VOLT_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [VOLT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/bvm_fifo.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor decoupling queue
// Small register queue that parts the accumulator from the voltage sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_fifo #(
  parameter int DATA_W = 19,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bvm_front.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor front end
// Accumulates readings and marks the one that closes each block.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_front import bvm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 20,
  parameter int SUM_W             = 17
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]         sum_total,
  output logic                     last
);

  localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK + 1);

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;

  assign sum_total = sum_r + SUM_W'(sample);
  assign last      = (cnt_r == CNT_W'(SAMPLES_PER_BLOCK - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_total;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bvm_div.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_div import bvm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(VOLT_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVS_W-1:0]  rem_r;
  logic [VOLT_W-1:0] quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, quo_r[VOLT_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(VOLT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[VOLT_W-2:0], fits};
      rem_r <= fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bvm_back.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor back end
// Recomputes the voltage at block ends, grades it on request and holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_back import bvm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 20,
  parameter int SUM_W             = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             q_empty,
  input  wire logic [SUM_W-1:0] q_sum,
  input  wire logic             q_last,
  input  wire logic             q_classify,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  wire div_rsp_t         div_rsp,
  output logic                  out_valid,
  input  wire logic             out_take,
  output logic [VOLT_W-1:0]     voltage_mv,
  output logic [LEVEL_W-1:0]    level,
  output logic                  updated
);

  // The block average is a multiply by a rounded-up reciprocal of the block
  // size. The shift leaves enough headroom for the result to be exact for
  // every sum the accumulator can hold.
  localparam int     RCP_SH  = SUM_W + $clog2(SAMPLES_PER_BLOCK);
  localparam int     RCP_W   = SUM_W + 1;
  localparam int     PROD_W  = SUM_W + RCP_W;
  localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(SAMPLES_PER_BLOCK) - 1)
                               / longint'(SAMPLES_PER_BLOCK);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VOLT,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic               start_r;
  logic [VOLT_W-1:0]  dividend_r;
  logic [DVS_W-1:0]   divisor_r;
  logic [VOLT_W-1:0]  held_volt_r;
  logic [LEVEL_W-1:0] held_lvl_r;
  logic               out_valid_r;
  logic [VOLT_W-1:0]  out_volt_r;
  logic [LEVEL_W-1:0] out_lvl_r;
  logic               out_upd_r;
  logic               slot_free;
  logic [LEVEL_W-1:0] grade_now;
  logic [LEVEL_W-1:0] lvl_nxt;
  logic [PROD_W-1:0]  avg_prod;
  logic [DVS_W-1:0]   blk_avg;

  assign slot_free = !out_valid_r || out_take;
  assign q_pop     = (state_r == ST_EMIT) && slot_free;

  assign avg_prod = PROD_W'(q_sum) * PROD_W'(RCP);
  assign blk_avg  = DVS_W'(avg_prod >> RCP_SH);

  // A voltage equal to a threshold drops into the lower grade.
  always_comb begin
    if (held_volt_r > VOLT_W'(cfg.high_thr)) begin
      grade_now = LVL_OK;
    end else if (held_volt_r > VOLT_W'(cfg.low_thr)) begin
      grade_now = LVL_LOW;
    end else begin
      grade_now = LVL_CRIT;
    end
  end

  assign lvl_nxt = q_classify ? grade_now : held_lvl_r;

  assign div_req.start    = start_r;
  assign div_req.dividend = dividend_r;
  assign div_req.divisor  = divisor_r;

  assign out_valid  = out_valid_r;
  assign voltage_mv = out_volt_r;
  assign level      = out_lvl_r;
  assign updated    = out_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      held_volt_r <= '0;
      held_lvl_r  <= LVL_OK;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_last) begin
              // A zero average saturates instead of dividing.
              if (blk_avg == '0) begin
                held_volt_r <= VOLT_MAX;
                state_r     <= ST_EMIT;
              end else begin
                start_r    <= 1'b1;
                dividend_r <= cfg.scale;
                divisor_r  <= blk_avg;
                state_r    <= ST_VOLT;
              end
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_VOLT: begin
          if (div_rsp.done) begin
            held_volt_r <= div_rsp.quotient;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_volt_r  <= held_volt_r;
            out_lvl_r   <= lvl_nxt;
            out_upd_r   <= q_last;
            held_lvl_r  <= lvl_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor: supply voltage from internal reference readings
// Each beat passes from the sample queue through the back-end sequencer, and the
// beat that closes a block also waits there for one 24-step divider pass.
// The sequencer finishes one beat before it takes the next; the beat that
// closes a block holds the back end for the whole divider pass.
// Synchronous reset clears sums, held voltage, grade, queue; loads settings.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_monitor import bvm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel: a beat is taken when push is high and full is low.
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  in_classify_enable,
  // Result channel: the oldest result is shown while empty is low.
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [VOLT_W-1:0]          out_voltage_mv,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_average_updated,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // The running sum must hold a full block of maximum readings.
  localparam int SUM_W   = $clog2((2 ** SAMPLE_W - 1) * SAMPLES_PER_BLOCK + 1);
  localparam int ENTRY_W = SUM_W + 2;
  localparam int Q_DEPTH = 4;

  // Configuration registers. Writes to an unused index are dropped.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale    <= SCALE_RESET;
      cfg_r.high_thr <= HIGH_RESET;
      cfg_r.low_thr  <= LOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: cfg_r.scale    <= cfg_data;
        REG_HIGH:  cfg_r.high_thr <= cfg_data[THR_W-1:0];
        REG_LOW:   cfg_r.low_thr  <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: the accumulator sees every accepted beat and tags the one
  // that completes a block, so the back end only has to read the tag.
  logic               in_accept;
  logic [SUM_W-1:0]   sum_total;
  logic               blk_last;
  logic [ENTRY_W-1:0] q_wr_data;
  logic [ENTRY_W-1:0] q_rd_data;
  logic               q_empty;
  logic               q_pop;

  assign in_accept = in_push && !in_full;

  bvm_front #(
    .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
    .SUM_W             (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .sample    (in_sample),
    .sum_total (sum_total),
    .last      (blk_last)
  );

  assign q_wr_data = {in_classify_enable, blk_last, sum_total};

  // The queue lets the front keep taking beats while the back end is busy
  // dividing at the end of a block.
  bvm_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (q_wr_data),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // Back end: a reciprocal multiply forms the block average, and the
  // iterative divider then gives the voltage as the scale numerator over
  // that average.
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_valid;

  bvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bvm_back #(
    .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
    .SUM_W             (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_sum      (q_rd_data[SUM_W-1:0]),
    .q_last     (q_rd_data[SUM_W]),
    .q_classify (q_rd_data[SUM_W+1]),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_take   (out_pop),
    .voltage_mv (out_voltage_mv),
    .level      (out_level),
    .updated    (out_average_updated)
  );

  assign out_empty = !out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/bvm_checker.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor port checker
// Watches the queue-style ports of the monitor over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "battery_voltage_monitor_defines.svh"

module bvm_checker import bvm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic [VOLT_W-1:0]  out_voltage_mv,
  input wire logic [LEVEL_W-1:0] out_level,
  input wire logic               out_average_updated
);

  // Beats accepted but not yet delivered.
  logic [3:0]                pending_r;
  logic                      in_acc;
  logic                      out_acc;
  logic                      out_wait;
  logic [VOLT_W+LEVEL_W:0]   out_beat;

  assign in_acc   = in_push && !in_full;
  assign out_acc  = out_pop && !out_empty;
  assign out_wait = !out_empty && !out_pop;
  assign out_beat = {out_voltage_mv, out_level, out_average_updated};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  `BVM_ASSERT_RST(a_reset_empty, !rst_n, out_empty, "result shown straight after reset")
  `BVM_ASSERT_NOW(a_no_phantom, pending_r == 4'd0, out_empty, "result without an input beat")
  `BVM_ASSERT_NOW(a_level_code, !out_empty, out_level <= LVL_CRIT, "undefined grade on output")
  `BVM_ASSERT_NEXT(a_hold, out_wait, !out_empty && $stable(out_beat), "stalled result changed")

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (.*);

`default_nettype wire

FILE: tb/sv/bvm_reading_checker.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor reading checker
// Watches the sample, result and register ports. It keeps its own copy of the
// block sum, held voltage and grade, and checks every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_reading_checker import bvm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic                  in_full,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  in_classify_enable,
  input  wire logic                  out_empty,
  input  wire logic                  out_pop,
  input  wire logic [VOLT_W-1:0]     out_voltage_mv,
  input  wire logic [LEVEL_W-1:0]    out_level,
  input  wire logic                  out_average_updated,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  // A block size of zero modulo 256 behaves as a block of one reading.
  localparam int BLOCK_LEN = (SAMPLES_PER_BLOCK % 256 == 0) ? 1 : SAMPLES_PER_BLOCK % 256;

  typedef struct packed {
    logic [VOLT_W-1:0]  voltage_mv;
    logic [LEVEL_W-1:0] level;
    logic               average_updated;
  } reading_t;

  cfg_t               settings;
  logic [19:0]        block_sum;
  logic [7:0]         block_fill;
  logic [VOLT_W-1:0]  held_mv;
  logic [LEVEL_W-1:0] held_grade;
  reading_t           readings_due[$];

  // Equality with a threshold falls into the lower grade.
  function automatic logic [LEVEL_W-1:0] grade_of(input logic [VOLT_W-1:0] mv, input cfg_t c);
    if (mv > c.high_thr) return LVL_OK;
    if (mv > c.low_thr) return LVL_LOW;
    return LVL_CRIT;
  endfunction

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_SCALE: begin
        settings.scale = d[VOLT_W-1:0];
      end
      REG_HIGH: begin
        settings.high_thr = d[THR_W-1:0];
      end
      REG_LOW: begin
        settings.low_thr = d[THR_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic classify);
    logic [19:0] mean;
    reading_t    r;
    r.average_updated = 1'b0;
    block_sum  = block_sum + s;
    block_fill = block_fill + 8'd1;
    if (block_fill >= BLOCK_LEN) begin
      mean = 20'(block_sum / BLOCK_LEN);
      // A zero average saturates rather than dividing by zero.
      held_mv = (mean == 0) ? VOLT_MAX : VOLT_W'(settings.scale / mean);
      block_sum  = '0;
      block_fill = '0;
      r.average_updated = 1'b1;
    end
    if (classify) held_grade = grade_of(held_mv, settings);
    r.voltage_mv = held_mv;
    r.level      = held_grade;
    readings_due.push_back(r);
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      $error("unexpected result beat: voltage_mv %0d level %0d average_updated %0d",
             out_voltage_mv, out_level, out_average_updated);
      fail_count++;
    end else begin
      want = readings_due.pop_front();
      if (out_voltage_mv !== want.voltage_mv) begin
        $error("voltage_mv: expected %0d, actual %0d", want.voltage_mv, out_voltage_mv);
        fail_count++;
      end
      if (out_level !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, out_level);
        fail_count++;
      end
      if (out_average_updated !== want.average_updated) begin
        $error("average_updated: expected %0d, actual %0d",
               want.average_updated, out_average_updated);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.scale    = SCALE_RESET;
      settings.high_thr = HIGH_RESET;
      settings.low_thr  = LOW_RESET;
      block_sum  = '0;
      block_fill = '0;
      held_mv    = '0;
      held_grade = LVL_OK;
      readings_due.delete();
    end else begin
      if (cfg_we) write_setting(cfg_index, cfg_data);
      if (in_push && in_full === 1'b0) absorb_sample(in_sample, in_classify_enable);
      if (out_pop && out_empty === 1'b0) check_reading();
    end
    pending = readings_due.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor testbench
// Drives reference readings through the sample queue under several register
// settings, with random gaps on both sides and one long result stall. The
// reading checker predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_battery_voltage_monitor;
  import bvm_pkg::*;

  localparam int BLOCK_LEN     = 20;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 9;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {STYLE_STEADY, STYLE_NOISY, STYLE_NEAR_ZERO, STYLE_CONSTANT} block_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  in_classify_enable;
  logic                  out_empty;
  logic                  out_pop;
  logic [VOLT_W-1:0]     out_voltage_mv;
  logic [LEVEL_W-1:0]    out_level;
  logic                  out_average_updated;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int beats_sent;
  int cycle_count;
  bit long_hold_req;

  battery_voltage_monitor #(.SAMPLES_PER_BLOCK(BLOCK_LEN)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_sample           (in_sample),
    .in_classify_enable  (in_classify_enable),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_voltage_mv      (out_voltage_mv),
    .out_level           (out_level),
    .out_average_updated (out_average_updated),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  bvm_reading_checker #(.SAMPLES_PER_BLOCK(BLOCK_LEN)) u_reading_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_sample           (in_sample),
    .in_classify_enable  (in_classify_enable),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_voltage_mv      (out_voltage_mv),
    .out_level           (out_level),
    .out_average_updated (out_average_updated),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. The slowest legal run is far below this limit, even with every
  // beat meeting a long sender gap, a long receiver gap and a divider pass.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL battery_voltage_monitor");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return v[SAMPLE_W-1:0];
  endfunction

  // The receiver pops in its own process. It idles in random gaps, has calm
  // stretches with no idling at all, and on request holds off for a long
  // stretch so that the sample queue fills and the block pushes back.
  initial begin : receiver
    int idle_left;
    int calm_left;
    bit pop_now;
    idle_left = 0;
    calm_left = 0;
    out_pop   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        idle_left = LONG_HOLD;
      end else if (idle_left == 0) begin
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 5) begin
          calm_left = $urandom_range(50, 200);
        end else begin
          idle_left = pause_length();
        end
      end
      pop_now = (idle_left == 0);
      if (idle_left > 0) idle_left--;
      out_pop <= pop_now;
    end
  end

  // Offers one beat from a falling edge and returns at the falling edge after
  // it has been taken. The push stays high, so back-to-back beats need no
  // lowering in between.
  task automatic send_reading(input logic [SAMPLE_W-1:0] s, input logic classify);
    in_push            <= 1'b1;
    in_sample          <= s;
    in_classify_enable <= classify;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic sender_pause(input bit no_gaps);
    int g;
    g = no_gaps ? 0 : pause_length();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    in_push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // The threshold registers are 16 bits wide; the upper data bits carry
  // junk which the block must drop.
  task automatic apply_settings(input logic [VOLT_W-1:0] scale, input logic [THR_W-1:0] high,
                                input logic [THR_W-1:0] low);
    write_register(REG_SCALE, scale);
    write_register(REG_HIGH, {8'($urandom_range(0, 255)), high});
    write_register(REG_LOW, {8'($urandom_range(0, 255)), low});
  endtask

  task automatic wait_for_results();
    while (pending != 0) @(negedge clk);
  endtask

  // A block of identical readings with grading on, so the held voltage is
  // exactly the scale divided by that reading.
  task automatic send_block(input logic [SAMPLE_W-1:0] s);
    repeat (BLOCK_LEN) begin
      send_reading(s, 1'b1);
      sender_pause(1'b0);
    end
  endtask

  // Random beats shaped per block: half the blocks hover around a centre chosen
  // to put the voltage near the thresholds, others are noise, constant, or
  // close enough to zero that the average nearly always truncates to zero.
  task automatic run_phase(input int beats, input logic [SAMPLE_W-1:0] centre, input bit no_gaps);
    block_style_t        style;
    logic [SAMPLE_W-1:0] anchor;
    logic [SAMPLE_W-1:0] s;
    int                  r;
    style  = STYLE_STEADY;
    anchor = centre;
    repeat (beats) begin
      if (beats_sent % BLOCK_LEN == 0) begin
        r = $urandom_range(0, 99);
        style = (r < 50) ? STYLE_STEADY : (r < 75) ? STYLE_NOISY :
                (r < 85) ? STYLE_NEAR_ZERO : STYLE_CONSTANT;
        anchor = clamp_sample(int'(centre) + $urandom_range(0, 40) - 20);
        if ($urandom_range(0, 9) == 0) anchor = $urandom_range(0, 1) ? 12'hFFF : 12'h001;
      end
      case (style)
        STYLE_STEADY: begin
          s = clamp_sample(int'(anchor) + $urandom_range(0, 14) - 7);
        end
        STYLE_NOISY: begin
          s = SAMPLE_W'($urandom_range(0, 4095));
        end
        STYLE_NEAR_ZERO: begin
          s = SAMPLE_W'($urandom_range(0, 1));
        end
        default: begin
          s = anchor;
        end
      endcase
      send_reading(s, $urandom_range(0, 3) != 0);
      sender_pause(no_gaps);
    end
    stop_sending();
  endtask

  initial begin : stimulus
    logic [VOLT_W-1:0]   scale;
    logic [THR_W-1:0]    high;
    logic [THR_W-1:0]    low;
    logic [SAMPLE_W-1:0] centre;
    int                  p;

    rst_n              = 1'b0;
    in_push            = 1'b0;
    in_sample          = '0;
    in_classify_enable = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_SCALE;
    cfg_data           = '0;
    beats_sent         = 0;
    cycle_count        = 0;
    long_hold_req      = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings. The first block sums to 19,
    // so its average truncates to zero and the voltage must saturate; the
    // grading before that sees a held voltage of zero. A few extreme
    // readings then start the next block.
    for (p = 0; p < BLOCK_LEN - 1; p++) begin
      send_reading('0, p[0]);
      sender_pause(1'b0);
    end
    send_reading(12'd19, 1'b1);
    send_reading(12'hFFF, 1'b1);
    send_reading(12'h000, 1'b0);
    send_reading(12'hFFF, 1'b1);
    send_reading(12'h800, 1'b0);
    send_reading(12'h001, 1'b1);
    stop_sending();
    wait_for_results();

    // A write to the unused index must be ignored.
    write_register(REG_SPARE, 24'($urandom_range(0, 24'hFF_FFFF)));

    for (p = 0; p < PHASES; p++) begin
      centre = SAMPLE_W'($urandom_range(1, 4095));
      case (p)
        0: begin
          // A zero scale gives a quotient of zero, held as such.
          apply_settings('0, HIGH_RESET, LOW_RESET);
        end
        1: begin
          apply_settings(VOLT_MAX, 16'hFFFF, 16'h0000);
        end
        2: begin
          apply_settings(24'd1, 16'h0000, 16'h0000);
        end
        3: begin
          // Low threshold above the high one: only ok and critical remain.
          apply_settings(SCALE_RESET, 16'd2000, 16'd3000);
          centre = 12'd2507;
        end
        4: begin
          // Voltages landing exactly on each threshold. With a scale of
          // 4800000 a steady 2000 gives 2400 and a steady 2181 gives 2200,
          // both of which must take the lower grade.
          apply_settings(24'd4_800_000, 16'd2400, 16'd2200);
          while (beats_sent % BLOCK_LEN != 0) begin
            send_reading(SAMPLE_W'($urandom_range(0, 4095)), 1'b1);
            sender_pause(1'b0);
          end
          send_block(12'd2000);
          send_block(12'd2181);
          send_block(12'd2000);
          centre = 12'd2000;
        end
        default: begin
          scale = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'hFF_FFFF))
                                              : 24'($urandom_range(3_000_000, 7_000_000));
          high  = THR_W'($urandom_range(1500, 4000));
          low   = ($urandom_range(0, 4) == 0) ? THR_W'(high + $urandom_range(1, 300))
                                              : THR_W'(high - $urandom_range(0, 500));
          apply_settings(scale, high, low);
          centre = clamp_sample(int'(scale / high));
        end
      endcase
      // In the pressure phase the receiver stalls for a long stretch while
      // the sender keeps offering beats without gaps.
      if (p == 5) long_hold_req = 1'b1;
      run_phase((p == 4) ? 40 : $urandom_range(80, 120), centre,
                (p == 5) || ($urandom_range(0, 3) == 0));
      wait_for_results();
    end

    // Let any stray beat show itself before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS battery_voltage_monitor");
    end else begin
      $display("FAIL battery_voltage_monitor");
    end
    $finish;
  end

endmodule

`default_nettype wire
